[rtl/rdcw_pkg.sv]
// shared types and constants for the range distinct-count window unit
// no dependencies; imported by the top module, the count unit and the bench

package rdcw_pkg;

    // default sizes of the element store and the value range
    localparam int DEF_ELEMENT_DEPTH = 1024;
    localparam int DEF_VALUE_LIMIT   = 1024;

    // fixed port widths
    localparam int IN_W  = 10;
    localparam int OUT_W = 11;

    // item mode codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // one count update travelling down the read-modify-write pipeline
    typedef struct packed {
        logic valid;
        logic inc;      // 1 takes a value in, 0 drops it out
    } t_cnt_op;

    // status of the count unit seen by the sequencer
    typedef struct packed {
        logic busy;     // an update is in its final stage
        logic clearing; // post-reset sweep of the count memory
    } t_cnt_status;

endpackage

[rtl/range_distinct_count_window_unit.sv]
// Range distinct-count window unit: keeps an element store and a sliding window
// [start, end) over it, with a per-value occurrence count and a running number of
// distinct values. A write transfer (mode 0) stores a value at a position; when the
// position lies in the window the old value is dropped out and the new one taken in,
// so the counts stay exact. A query transfer (mode 1) walks the window edges one
// position per cycle to [left_end, right_end] and then returns one result transfer
// with the distinct count; left_end > right_end gives an empty window and 0. Writes
// to a position at or beyond ELEMENT_DEPTH, or of a value at or beyond VALUE_LIMIT,
// are dropped; right_end is clamped to the last position. Only written positions
// may be covered by a query. The rate is one edge move per cycle, set by the
// read-modify-write pipeline over the element store and the count memory (element
// read, count read, count write). A write outside the window passes through
// S_WR_STORE only; one inside it passes through S_WR_DROP, S_WR_STORE and
// S_WR_TAKE. After reset the count memory is swept to zero, address by address,
// while in_ready stays low. A finished result waits in the output register
// while the next transfer is taken in; a query that finishes while that register
// is still full holds in its drain state until the waiting result is taken.
// depends on rdcw_pkg, rdcw_elem_ram and rdcw_count_unit

module range_distinct_count_window_unit
    import rdcw_pkg::*;
#(
    parameter int ELEMENT_DEPTH = DEF_ELEMENT_DEPTH,
    parameter int VALUE_LIMIT   = DEF_VALUE_LIMIT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_mode,
    input  logic [IN_W-1:0]  i_position,
    input  logic [IN_W-1:0]  i_value,
    input  logic [IN_W-1:0]  i_left_end,
    input  logic [IN_W-1:0]  i_right_end,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [OUT_W-1:0] o_distinct_count
);

    localparam int POS_W = $clog2(ELEMENT_DEPTH);
    localparam int EW    = POS_W + 1;               // window edges reach the depth itself
    localparam int VW    = $clog2(VALUE_LIMIT);
    localparam int CNT_W = $clog2(ELEMENT_DEPTH + 1);
    // compare widths that hold both the port values and the limits
    localparam int XW    = (EW > IN_W + 1) ? EW : IN_W + 1;
    localparam int VXW   = (VW + 1 > IN_W + 1) ? VW + 1 : IN_W + 1;

    localparam logic [XW-1:0]  DEPTH_X = XW'(ELEMENT_DEPTH);
    localparam logic [XW-1:0]  LAST_X  = XW'(ELEMENT_DEPTH - 1);
    localparam logic [VXW-1:0] VLIM_X  = VXW'(VALUE_LIMIT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUERY,
        S_DRAIN,
        S_WR_DROP,
        S_WR_STORE,
        S_WR_TAKE
    } t_state;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_GROW_END,
        STEP_GROW_START,
        STEP_SHRINK_START,
        STEP_SHRINK_END
    } t_step;

    t_state           r_state;
    logic [EW-1:0]    r_start;
    logic [EW-1:0]    r_end;
    logic [EW-1:0]    r_ns;
    logic [EW-1:0]    r_ne;
    logic [POS_W-1:0] r_wpos;
    logic [VW-1:0]    r_wval;
    logic             r_wr_take;
    t_cnt_op          r_b_op;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_count;

    logic [XW-1:0]    pos_x;
    logic [XW-1:0]    left_x;
    logic [XW-1:0]    right_x;
    logic [VXW-1:0]   val_x;
    logic [XW-1:0]    hi_x;
    logic [XW-1:0]    lo_x;
    logic [XW-1:0]    ne_x;
    logic             wr_ok;
    logic             in_window;
    logic             in_fire;
    logic             pipe_empty;
    logic             res_load;

    logic [EW-1:0]    start_dec;
    logic [EW-1:0]    end_dec;
    t_step            step;
    logic             iss_valid;
    logic             iss_inc;
    logic [POS_W-1:0] iss_pos;

    logic [VW-1:0]              elem_rdata;
    logic [CNT_W-1:0]           distinct;
    logic [CNT_W+OUT_W-1:0]     dist_x;
    t_cnt_status                cnt_status;

    // ------------------------------------------------------------------
    // input decode: range checks and query clamping
    // ------------------------------------------------------------------
    assign pos_x   = XW'(i_position);
    assign left_x  = XW'(i_left_end);
    assign right_x = XW'(i_right_end);
    assign val_x   = VXW'(i_value);

    assign hi_x  = (right_x > LAST_X) ? LAST_X : right_x;
    assign lo_x  = (left_x >= DEPTH_X) ? DEPTH_X : left_x;
    // an empty range collapses the window onto left_end
    assign ne_x  = (lo_x <= hi_x) ? (hi_x + XW'(1)) : lo_x;

    assign wr_ok     = (pos_x < DEPTH_X) && (val_x < VLIM_X);
    assign in_window = (pos_x >= XW'(r_start)) && (pos_x < XW'(r_end));

    assign o_in_ready = (r_state == S_IDLE) && !cnt_status.clearing;
    assign in_fire    = i_in_valid && o_in_ready;

    // nothing left in the element read stage or the count update stage
    assign pipe_empty = !r_b_op.valid && !cnt_status.busy;

    // result register takes the count once the last update has landed and there is room
    assign res_load = (r_state == S_DRAIN) && pipe_empty && (!r_out_valid || i_out_ready);

    // ------------------------------------------------------------------
    // step issue: one element position per cycle into the update pipeline
    // order is grow end, grow start, shrink start, shrink end
    // ------------------------------------------------------------------
    assign start_dec = r_start - EW'(1);
    assign end_dec   = r_end - EW'(1);

    always_comb begin
        step      = STEP_NONE;
        iss_valid = 1'b0;
        iss_inc   = 1'b0;
        iss_pos   = r_wpos;
        unique case (r_state)
            S_QUERY: begin
                priority if (r_end < r_ne) begin
                    step    = STEP_GROW_END;
                    iss_inc = 1'b1;
                    iss_pos = r_end[POS_W-1:0];
                end else if (r_start > r_ns) begin
                    step    = STEP_GROW_START;
                    iss_inc = 1'b1;
                    iss_pos = start_dec[POS_W-1:0];
                end else if (r_start < r_ns) begin
                    step    = STEP_SHRINK_START;
                    iss_pos = r_start[POS_W-1:0];
                end else if (r_end > r_ne) begin
                    step    = STEP_SHRINK_END;
                    iss_pos = end_dec[POS_W-1:0];
                end else begin
                    step    = STEP_NONE;
                end
                iss_valid = (step != STEP_NONE);
            end
            // old value leaves before the store is overwritten
            S_WR_DROP: begin
                iss_valid = 1'b1;
            end
            // new value enters, read back from the store after the write
            S_WR_TAKE: begin
                iss_valid = 1'b1;
                iss_inc   = 1'b1;
            end
            default: begin
                iss_valid = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer and result register
    // ------------------------------------------------------------------
    assign dist_x = {OUT_W'(0), distinct};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= '0;
            r_end       <= '0;
            r_b_op      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_b_op.valid <= iss_valid;
            r_b_op.inc   <= iss_inc;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_mode == MODE_QUERY) begin
                            r_ns    <= lo_x[EW-1:0];
                            r_ne    <= ne_x[EW-1:0];
                            r_state <= S_QUERY;
                        end else if (wr_ok) begin
                            r_wpos    <= pos_x[POS_W-1:0];
                            r_wval    <= val_x[VW-1:0];
                            r_wr_take <= in_window;
                            r_state   <= in_window ? S_WR_DROP : S_WR_STORE;
                        end
                    end
                end
                S_QUERY: begin
                    unique case (step)
                        STEP_GROW_END:     r_end   <= r_end + EW'(1);
                        STEP_GROW_START:   r_start <= start_dec;
                        STEP_SHRINK_START: r_start <= r_start + EW'(1);
                        STEP_SHRINK_END:   r_end   <= end_dec;
                        default:           r_state <= S_DRAIN;
                    endcase
                end
                S_DRAIN: begin
                    // wait for the last count update, then for room in the result register
                    if (res_load) begin
                        r_out_count <= dist_x[OUT_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                S_WR_DROP: begin
                    r_state <= S_WR_STORE;
                end
                S_WR_STORE: begin
                    r_state <= r_wr_take ? S_WR_TAKE : S_IDLE;
                end
                S_WR_TAKE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // outside the window a write needs no count update
    // (S_WR_STORE goes on to S_WR_TAKE only when the drop was issued)

    // ------------------------------------------------------------------
    // element store and count unit
    // ------------------------------------------------------------------
    rdcw_elem_ram #(
        .DEPTH (ELEMENT_DEPTH),
        .WIDTH (VW)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR_STORE),
        .i_waddr (r_wpos),
        .i_wdata (r_wval),
        .i_raddr (iss_pos),
        .o_rdata (elem_rdata)
    );

    rdcw_count_unit #(
        .ELEMENT_DEPTH (ELEMENT_DEPTH),
        .VALUE_LIMIT   (VALUE_LIMIT)
    ) u_count_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (r_b_op),
        .i_value    (elem_rdata),
        .o_distinct (distinct),
        .o_status   (cnt_status)
    );

    assign o_out_valid      = r_out_valid;
    assign o_distinct_count = r_out_count;

endmodule

[rtl/rdcw_elem_ram.sv]
// element store: simple dual-port memory, one write and one registered read
// depends on nothing but its parameters

module rdcw_elem_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rdcw_count_unit.sv]
// occurrence count memory with its read-modify-write stage and the distinct total
// uses rdcw_pkg for the update and status structs

module rdcw_count_unit
    import rdcw_pkg::*;
#(
    parameter int ELEMENT_DEPTH = DEF_ELEMENT_DEPTH,
    parameter int VALUE_LIMIT   = DEF_VALUE_LIMIT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_cnt_op                              i_op,
    input  logic [$clog2(VALUE_LIMIT)-1:0]       i_value,
    output logic [$clog2(ELEMENT_DEPTH+1)-1:0]   o_distinct,
    output t_cnt_status                          o_status
);

    localparam int VW    = $clog2(VALUE_LIMIT);
    localparam int CNT_W = $clog2(ELEMENT_DEPTH + 1);
    localparam logic [VW-1:0] LAST_VALUE = VW'(VALUE_LIMIT - 1);

    logic [CNT_W-1:0] r_mem [VALUE_LIMIT];
    logic [CNT_W-1:0] r_rdata;

    logic             r_c_valid;
    logic             r_c_inc;
    logic [VW-1:0]    r_c_addr;

    logic             r_fwd_valid;
    logic [VW-1:0]    r_fwd_addr;
    logic [CNT_W-1:0] r_fwd_data;

    logic             r_clearing;
    logic [VW-1:0]    r_clr_addr;
    logic [CNT_W-1:0] r_distinct;

    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] upd;
    logic             upd_we;
    logic             mem_we;
    logic [VW-1:0]    mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic [CNT_W-1:0] n_distinct;

    // the write of the previous update is not yet in the read data
    assign cur = (r_fwd_valid && (r_fwd_addr == r_c_addr)) ? r_fwd_data : r_rdata;

    always_comb begin
        upd        = cur;
        upd_we     = 1'b0;
        n_distinct = r_distinct;
        if (r_c_valid) begin
            if (r_c_inc) begin
                upd    = cur + CNT_W'(1);
                upd_we = 1'b1;
                if (cur == '0) begin
                    n_distinct = r_distinct + CNT_W'(1);
                end
            end else if (cur != '0) begin
                upd    = cur - CNT_W'(1);
                upd_we = 1'b1;
                if ((upd == '0) && (r_distinct != '0)) begin
                    n_distinct = r_distinct - CNT_W'(1);
                end
            end
        end
    end

    assign mem_we    = r_clearing || upd_we;
    assign mem_waddr = r_clearing ? r_clr_addr : r_c_addr;
    assign mem_wdata = r_clearing ? '0 : upd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[i_value];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_distinct  <= '0;
        end else begin
            r_c_valid   <= i_op.valid;
            r_fwd_valid <= upd_we;
            r_distinct  <= n_distinct;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + VW'(1);
                if (r_clr_addr == LAST_VALUE) begin
                    r_clearing <= 1'b0;
                end
            end
        end
        r_c_inc    <= i_op.inc;
        r_c_addr   <= i_value;
        r_fwd_addr <= r_c_addr;
        r_fwd_data <= upd;
    end

    assign o_distinct      = r_distinct;
    assign o_status.busy     = r_c_valid;
    assign o_status.clearing = r_clearing;

endmodule

[bench/range_distinct_count_window_unit_tb.sv]
// self-checking bench for range_distinct_count_window_unit: write and query transfers
// are checked against a scoreboard that tracks the window and the distinct count
// depends on rdcw_pkg and the block's rtl, nothing else
`timescale 1ns / 1ps

module range_distinct_count_window_unit_tb
    import rdcw_pkg::*;
;

    localparam int DEPTH       = DEF_ELEMENT_DEPTH;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ITEMS_TOTAL = 600;   // input transfers in all, fills included

    // window tracker: element store, per-value counts and the running distinct total
    class distinct_scoreboard;
        bit [IN_W-1:0]  elem [DEPTH];
        bit             written [DEPTH];
        int unsigned    occ [DEPTH];
        int unsigned    win_lo;
        int unsigned    win_end;
        int unsigned    distinct;
        bit [OUT_W-1:0] counts_due [$];
        int             errors;

        function void take_in(int unsigned p);
            bit [IN_W-1:0] v;
            v = elem[p];
            if (occ[v] == 0) distinct++;
            occ[v]++;
        endfunction

        function void drop_out(int unsigned p);
            bit [IN_W-1:0] v;
            v = elem[p];
            if (occ[v] == 0) return;
            occ[v]--;
            if (occ[v] == 0 && distinct > 0) distinct--;
        endfunction

        // one accepted input transfer
        function void note_input(logic m, logic [IN_W-1:0] pos, logic [IN_W-1:0] val,
                                 logic [IN_W-1:0] lo, logic [IN_W-1:0] hi);
            bit          in_window;
            int unsigned ns;
            int unsigned ne;
            if (m == MODE_WRITE) begin
                in_window = (pos >= win_lo) && (pos < win_end);
                if (in_window) drop_out(pos);
                elem[pos]    = val;
                written[pos] = 1'b1;
                if (in_window) take_in(pos);
            end else begin
                ns = lo;
                ne = (lo <= hi) ? hi + 1 : lo;
                // grow first, then shrink, so the window stays contiguous
                while (win_end < ne) begin
                    take_in(win_end);
                    win_end++;
                end
                while (win_lo > ns) begin
                    win_lo--;
                    take_in(win_lo);
                end
                while (win_lo < ns) begin
                    drop_out(win_lo);
                    win_lo++;
                end
                while (win_end > ne) begin
                    win_end--;
                    drop_out(win_end);
                end
                counts_due.push_back(distinct[OUT_W-1:0]);
            end
        endfunction

        // one accepted result transfer
        function void check_result(logic [OUT_W-1:0] got);
            bit [OUT_W-1:0] want;
            if (counts_due.size() == 0) begin
                $error("distinct_count: expected none, got %0d", got);
                errors++;
            end else begin
                want = counts_due.pop_front();
                if (got !== want) begin
                    $error("distinct_count: expected %0d, got %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             mode;
    logic [IN_W-1:0]  position;
    logic [IN_W-1:0]  value;
    logic [IN_W-1:0]  left_end;
    logic [IN_W-1:0]  right_end;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [OUT_W-1:0] distinct_count;

    distinct_scoreboard sb = new;
    bit                 calm = 1'b0;   // high during the stretch with no idling
    int                 cycle_count = 0;
    int                 n_sent = 0;

    range_distinct_count_window_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_mode           (mode),
        .i_position       (position),
        .i_value          (value),
        .i_left_end       (left_end),
        .i_right_end      (right_end),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_distinct_count (distinct_count)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // timeout guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side stalls about 11 percent of the time, never in the calm stretch
    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    // result monitor, sampled on the rising edge
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(distinct_count);
    end

    // one input transfer; entered and left just after a falling edge
    task automatic send_item(logic m, logic [IN_W-1:0] p, logic [IN_W-1:0] v,
                             logic [IN_W-1:0] l, logic [IN_W-1:0] r);
        while (!calm && $urandom_range(0, 99) < 11) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        position  <= p;
        value     <= v;
        left_end  <= l;
        right_end <= r;
        do @(posedge clk); while (!in_ready);
        sb.note_input(m, p, v, l, r);
        n_sent++;
        @(negedge clk);
    endtask

    // unused fields carry random junk
    task automatic write_item(int p, int v);
        send_item(MODE_WRITE, p[IN_W-1:0], v[IN_W-1:0], IN_W'($urandom), IN_W'($urandom));
    endtask

    task automatic query_item(int l, int r);
        send_item(MODE_QUERY, IN_W'($urandom), IN_W'($urandom), l[IN_W-1:0], r[IN_W-1:0]);
    endtask

    // mostly a small palette so windows hold repeats, sometimes the full range
    function automatic int pick_value();
        return ($urandom_range(0, 99) < 70) ? $urandom_range(0, 31)
                                            : $urandom_range(0, DEPTH - 1);
    endfunction

    // the window walk reads every position it passes, so write any gap first
    task automatic fill_span(int a, int b);
        for (int p = a; p < b; p++) begin
            if (!sb.written[p]) write_item(p, pick_value());
        end
    endtask

    initial begin
        int center;
        int goal;
        int step;
        int kind;
        int w;
        int lo;
        int hi;
        int end_x;
        int span_lo;
        int span_hi;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = MODE_WRITE;
        position  = '0;
        value     = '0;
        left_end  = '0;
        right_end = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extreme values, repeats, shrink on both edges, empty ranges,
        // writes inside and outside the window
        write_item(0, 0);
        write_item(1, DEPTH - 1);
        write_item(2, 5);
        write_item(3, 5);
        write_item(4, 0);
        query_item(0, 4);
        query_item(2, 3);
        query_item(3, 2);       // empty range
        query_item(0, 0);
        write_item(0, 5);       // in window, old value replaced
        query_item(0, 0);
        query_item(0, 4);
        write_item(4, 7);       // in window, new value
        query_item(0, 4);
        query_item(4, 0);       // empty range, window collapses at left_end
        query_item(1, 1);
        write_item(DEPTH - 1, DEPTH - 1);
        write_item(DEPTH - 2, 512);
        write_item(2, DEPTH - 1);
        query_item(1, 2);

        // random: the window walks back and forth across the store
        center = 0;
        goal   = DEPTH - 1;
        while (n_sent < ITEMS_TOTAL) begin
            calm = (n_sent >= 250 && n_sent < 400);
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 1) == 0 && sb.win_end > sb.win_lo)
                    write_item($urandom_range(sb.win_lo, sb.win_end - 1), pick_value());
                else
                    write_item($urandom_range(0, DEPTH - 1), pick_value());
            end else begin
                step = $urandom_range(0, 40);
                if ($urandom_range(0, 99) < 80)
                    center += (goal > center) ? step : -step;
                else
                    center -= (goal > center) ? step / 2 : -(step / 2);
                if (center < 0) center = 0;
                if (center > DEPTH - 1) center = DEPTH - 1;
                if (goal == DEPTH - 1 && center == DEPTH - 1) goal = 0;
                else if (goal == 0 && center == 0) goal = DEPTH - 1;

                kind = $urandom_range(0, 99);
                if (kind < 10) begin
                    // empty range: left_end above right_end
                    lo = (center == 0) ? 1 : center;
                    hi = lo - $urandom_range(1, (lo < 16) ? lo : 16);
                end else begin
                    w  = (kind < 20) ? $urandom_range(41, 200) : $urandom_range(1, 40);
                    lo = center - w / 2;
                    if (lo < 0) lo = 0;
                    hi = lo + w - 1;
                    if (hi > DEPTH - 1) hi = DEPTH - 1;
                end
                end_x   = (lo <= hi) ? hi + 1 : lo;
                span_lo = (sb.win_lo < lo) ? sb.win_lo : lo;
                span_hi = (sb.win_end > end_x) ? sb.win_end : end_x;
                fill_span(span_lo, span_hi);
                query_item(lo, hi);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain, then leave room for a late or spurious result
        while (sb.counts_due.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        if (sb.errors == 0 && sb.counts_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (sb.counts_due.size() != 0)
                $error("distinct_count: %0d results never arrived", sb.counts_due.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
